@@ rtl/rgb_window_median_filter_assert.svh @@
// Assertion helpers for the window median filter checker.
`ifndef RGB_WINDOW_MEDIAN_FILTER_ASSERT_SVH
`define RGB_WINDOW_MEDIAN_FILTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RWMF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rwmf: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RWMF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rwmf: next-cycle check failed");

`endif

@@ rtl/rwmf_pkg.sv @@
package rwmf_pkg;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam int CFG_DIM_W = 9;
  localparam int CFG_RAD_W = 2;
  localparam int COORD_W   = 8;
  localparam int CHAN_W    = 8;
  localparam int PIX_W     = 3 * CHAN_W;
  localparam int WCNT_W    = 6;

  // controller -> datapath
  typedef struct packed {
    logic wr_pix;    // write the load pixel into the frame store
    logic capture;   // latch query position and window setup
    logic scan;      // visit one window position
    logic shift;     // advance the sorted lists by one
    logic out_load;  // load the result register
  } rwmf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic oor;
    logic scan_last;
    logic shift_done;
    logic out_free;
  } rwmf_stat_t;

endpackage

@@ rtl/rgb_window_median_filter.sv @@
// Load: accepted while idle, no result.
// Query: scans every window position, then shifts the sorted lists up to the median and loads
// the result; the frame store's single read port (one window pixel per cycle) sets the scan length.
// Query outside the image: skips the scan and loads a zero result.
// One item at a time; inputs stall while a query is in progress.
// Reset: registers return to 256 x 256, radius 1 x 1; the frame store is not cleared.
module rgb_window_median_filter #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [3:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         cmd_i,
  input  logic [rwmf_pkg::COORD_W-1:0] col_x_i,
  input  logic [rwmf_pkg::COORD_W-1:0] row_y_i,
  input  logic [rwmf_pkg::CHAN_W-1:0]  in_red_i,
  input  logic [rwmf_pkg::CHAN_W-1:0]  in_green_i,
  input  logic [rwmf_pkg::CHAN_W-1:0]  in_blue_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rwmf_pkg::COORD_W-1:0] out_col_o,
  output logic [rwmf_pkg::COORD_W-1:0] out_row_o,
  output logic [rwmf_pkg::CHAN_W-1:0]  med_red_o,
  output logic [rwmf_pkg::CHAN_W-1:0]  med_green_o,
  output logic [rwmf_pkg::CHAN_W-1:0]  med_blue_o,
  output logic [rwmf_pkg::WCNT_W-1:0]  window_count_o,
  output logic                         out_of_range_o
);

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RAD_X  = 2'd2;
  localparam logic [1:0] REG_RAD_Y  = 2'd3;

  logic [rwmf_pkg::CFG_DIM_W-1:0] width_q, height_q;
  logic [rwmf_pkg::CFG_RAD_W-1:0] rad_x_q, rad_y_q;
  logic                           wr_en;
  logic [1:0]                     reg_idx;

  rwmf_pkg::rwmf_cmd_t  cmd;
  rwmf_pkg::rwmf_stat_t stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rwmf_pkg::CFG_DIM_W'(256);
      height_q <= rwmf_pkg::CFG_DIM_W'(256);
      rad_x_q  <= rwmf_pkg::CFG_RAD_W'(1);
      rad_y_q  <= rwmf_pkg::CFG_RAD_W'(1);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WIDTH:  width_q  <= pwdata[rwmf_pkg::CFG_DIM_W-1:0];
        REG_HEIGHT: height_q <= pwdata[rwmf_pkg::CFG_DIM_W-1:0];
        REG_RAD_X:  rad_x_q  <= pwdata[rwmf_pkg::CFG_RAD_W-1:0];
        REG_RAD_Y:  rad_y_q  <= pwdata[rwmf_pkg::CFG_RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:  prdata = 32'(width_q);
      REG_HEIGHT: prdata = 32'(height_q);
      REG_RAD_X:  prdata = 32'(rad_x_q);
      REG_RAD_Y:  prdata = 32'(rad_y_q);
      default:    prdata = '0;
    endcase
  end

  rwmf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rwmf_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_width_i    (width_q),
    .cfg_height_i   (height_q),
    .cfg_rad_x_i    (rad_x_q),
    .cfg_rad_y_i    (rad_y_q),
    .col_x_i        (col_x_i),
    .row_y_i        (row_y_i),
    .in_red_i       (in_red_i),
    .in_green_i     (in_green_i),
    .in_blue_i      (in_blue_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .out_col_o      (out_col_o),
    .out_row_o      (out_row_o),
    .med_red_o      (med_red_o),
    .med_green_o    (med_green_o),
    .med_blue_o     (med_blue_o),
    .window_count_o (window_count_o),
    .out_of_range_o (out_of_range_o)
  );

endmodule

@@ rtl/rwmf_ram.sv @@
module rwmf_ram #(
  parameter int Width = 24,
  parameter int Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/rwmf_sort.sv @@
// Insertion sorter: a row of cells kept in ascending order. Empty cells act
// as larger than any value. A shift moves every cell one place toward cell 0.
module rwmf_sort #(
  parameter int Cells = 49
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clr_i,
  input  logic                        ins_i,
  input  logic                        shift_i,
  input  logic [rwmf_pkg::CHAN_W-1:0] val_i,
  output logic [rwmf_pkg::CHAN_W-1:0] lo0_o,
  output logic [rwmf_pkg::CHAN_W-1:0] lo1_o
);

  logic [rwmf_pkg::CHAN_W-1:0] v_q [Cells];
  logic [rwmf_pkg::CHAN_W-1:0] v_d [Cells];
  logic [rwmf_pkg::CHAN_W-1:0] v_prev [Cells];
  logic [rwmf_pkg::CHAN_W-1:0] v_next [Cells];
  logic [Cells-1:0] vld_q, vld_d;
  logic [Cells-1:0] gt, gt_prev, vld_prev;

  always_comb begin
    v_prev[0]        = val_i;
    v_next[Cells-1]  = v_q[Cells-1];
    for (int c = 1; c < Cells; c++) begin
      v_prev[c]   = v_q[c-1];
      v_next[c-1] = v_q[c];
    end
    for (int c = 0; c < Cells; c++) begin
      gt[c] = !vld_q[c] || (v_q[c] > val_i);
    end
    gt_prev  = {gt[Cells-2:0], 1'b0};
    vld_prev = {vld_q[Cells-2:0], 1'b1};

    vld_d = vld_q;
    for (int c = 0; c < Cells; c++) begin
      v_d[c] = v_q[c];
    end
    if (clr_i) begin
      vld_d = '0;
    end else if (ins_i) begin
      vld_d = vld_q | vld_prev;
      for (int c = 0; c < Cells; c++) begin
        if (gt[c]) begin
          v_d[c] = gt_prev[c] ? v_prev[c] : val_i;
        end
      end
    end else if (shift_i) begin
      for (int c = 0; c < Cells; c++) begin
        v_d[c] = v_next[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < Cells; c++) begin
      v_q[c] <= v_d[c];
    end
  end

  assign lo0_o = v_q[0];
  assign lo1_o = v_q[1];

endmodule

@@ rtl/rwmf_ctrl.sv @@
module rwmf_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   cmd_i,
  output logic                   in_stall_o,
  input  rwmf_pkg::rwmf_stat_t   stat_i,
  output rwmf_pkg::rwmf_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (cmd_i == rwmf_pkg::CMD_LOAD) begin
            cmd_o.wr_pix = 1'b1;
          end else begin
            cmd_o.capture = 1'b1;
            state_d       = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (stat_i.oor) begin
          state_d = S_OUT;
        end else begin
          cmd_o.scan = 1'b1;
          if (stat_i.scan_last) begin
            state_d = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        // last frame store read lands in the sorters here
        state_d = S_SHIFT;
      end
      S_SHIFT: begin
        if (stat_i.shift_done) begin
          state_d = S_OUT;
        end else begin
          cmd_o.shift = 1'b1;
        end
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/rwmf_dp.sv @@
module rwmf_dp #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rwmf_pkg::rwmf_cmd_t            cmd_i,
  output rwmf_pkg::rwmf_stat_t           stat_o,
  input  logic [rwmf_pkg::CFG_DIM_W-1:0] cfg_width_i,
  input  logic [rwmf_pkg::CFG_DIM_W-1:0] cfg_height_i,
  input  logic [rwmf_pkg::CFG_RAD_W-1:0] cfg_rad_x_i,
  input  logic [rwmf_pkg::CFG_RAD_W-1:0] cfg_rad_y_i,
  input  logic [rwmf_pkg::COORD_W-1:0]   col_x_i,
  input  logic [rwmf_pkg::COORD_W-1:0]   row_y_i,
  input  logic [rwmf_pkg::CHAN_W-1:0]    in_red_i,
  input  logic [rwmf_pkg::CHAN_W-1:0]    in_green_i,
  input  logic [rwmf_pkg::CHAN_W-1:0]    in_blue_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic [rwmf_pkg::COORD_W-1:0]   out_col_o,
  output logic [rwmf_pkg::COORD_W-1:0]   out_row_o,
  output logic [rwmf_pkg::CHAN_W-1:0]    med_red_o,
  output logic [rwmf_pkg::CHAN_W-1:0]    med_green_o,
  output logic [rwmf_pkg::CHAN_W-1:0]    med_blue_o,
  output logic [rwmf_pkg::WCNT_W-1:0]    window_count_o,
  output logic                           out_of_range_o
);

  localparam int MaxDim  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int LimW    = ($clog2(MaxDim + 1) > rwmf_pkg::CFG_DIM_W) ?
                           $clog2(MaxDim + 1) : rwmf_pkg::CFG_DIM_W;
  localparam int PosW    = LimW + 1;
  localparam int RadW    = $clog2(MAX_RADIUS + 1);
  localparam int OffW    = RadW + 1;
  localparam int WinMax  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int CntW    = $clog2(WinMax + 1);
  localparam int Depth   = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW   = $clog2(Depth);
  localparam int CW      = rwmf_pkg::CHAN_W;

  // query setup
  logic [rwmf_pkg::COORD_W-1:0] cx_q, cy_q;
  logic [LimW-1:0]              w_q, h_q, w_sat, h_sat;
  logic [RadW-1:0]              rx_q, ry_q, rx_sat, ry_sat;
  logic                         oor_q;

  // window walk
  logic signed [OffW-1:0] i_q, j_q, rx_s, ry_s;
  logic signed [PosW-1:0] px, py;
  logic                   in_win;
  logic [CntW-1:0]        n_q, k_q, k_target;
  logic                   rd_pend_q;

  logic [AddrW-1:0]             waddr, raddr;
  logic                         load_ok;
  logic [rwmf_pkg::PIX_W-1:0]   rdata;
  logic [CW-1:0]                r_lo0, r_lo1, g_lo0, g_lo1, b_lo0, b_lo1;
  logic [CW-1:0]                r_med, g_med, b_med;
  logic [CW:0]                  r_sum, g_sum, b_sum;
  logic                         out_take;

  assign w_sat  = (int'(cfg_width_i) > MAX_WIDTH) ? LimW'(MAX_WIDTH) : LimW'(cfg_width_i);
  assign h_sat  = (int'(cfg_height_i) > MAX_HEIGHT) ? LimW'(MAX_HEIGHT)
                                                     : LimW'(cfg_height_i);
  assign rx_sat = (int'(cfg_rad_x_i) > MAX_RADIUS) ? RadW'(MAX_RADIUS) : RadW'(cfg_rad_x_i);
  assign ry_sat = (int'(cfg_rad_y_i) > MAX_RADIUS) ? RadW'(MAX_RADIUS) : RadW'(cfg_rad_y_i);

  assign rx_s = signed'(OffW'(rx_q));
  assign ry_s = signed'(OffW'(ry_q));

  assign px = PosW'(signed'({1'b0, cx_q})) + PosW'(i_q);
  assign py = PosW'(signed'({1'b0, cy_q})) + PosW'(j_q);
  assign in_win = !px[PosW-1] && !py[PosW-1] &&
                  (px[PosW-2:0] < w_q) && (py[PosW-2:0] < h_q);

  assign raddr   = AddrW'(py[PosW-2:0]) * AddrW'(MAX_WIDTH) + AddrW'(px[PosW-2:0]);
  assign load_ok = (int'(col_x_i) < MAX_WIDTH) && (int'(row_y_i) < MAX_HEIGHT);
  assign waddr   = AddrW'(row_y_i) * AddrW'(MAX_WIDTH) + AddrW'(col_x_i);

  // odd count: take the middle; even: stop one short and average two cells
  assign k_target = n_q[0] ? (n_q >> 1) : ((n_q >> 1) - CntW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.scan && in_win;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cx_q  <= col_x_i;
      cy_q  <= row_y_i;
      w_q   <= w_sat;
      h_q   <= h_sat;
      rx_q  <= rx_sat;
      ry_q  <= ry_sat;
      oor_q <= (LimW'(col_x_i) >= w_sat) || (LimW'(row_y_i) >= h_sat);
      i_q   <= -signed'(OffW'(rx_sat));
      j_q   <= -signed'(OffW'(ry_sat));
      n_q   <= '0;
      k_q   <= '0;
    end else begin
      if (cmd_i.scan) begin
        if (in_win) begin
          n_q <= n_q + CntW'(1);
        end
        if (i_q == rx_s) begin
          i_q <= -rx_s;
          j_q <= j_q + OffW'(1);
        end else begin
          i_q <= i_q + OffW'(1);
        end
      end
      if (cmd_i.shift) begin
        k_q <= k_q + CntW'(1);
      end
    end
  end

  rwmf_ram #(
    .Width (rwmf_pkg::PIX_W),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_pix && load_ok),
    .waddr_i (waddr),
    .wdata_i ({in_red_i, in_green_i, in_blue_i}),
    .re_i    (cmd_i.scan && in_win),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  rwmf_sort #(.Cells(WinMax)) u_sort_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (cmd_i.capture),
    .ins_i   (rd_pend_q),
    .shift_i (cmd_i.shift),
    .val_i   (rdata[3*CW-1:2*CW]),
    .lo0_o   (r_lo0),
    .lo1_o   (r_lo1)
  );

  rwmf_sort #(.Cells(WinMax)) u_sort_g (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (cmd_i.capture),
    .ins_i   (rd_pend_q),
    .shift_i (cmd_i.shift),
    .val_i   (rdata[2*CW-1:CW]),
    .lo0_o   (g_lo0),
    .lo1_o   (g_lo1)
  );

  rwmf_sort #(.Cells(WinMax)) u_sort_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (cmd_i.capture),
    .ins_i   (rd_pend_q),
    .shift_i (cmd_i.shift),
    .val_i   (rdata[CW-1:0]),
    .lo0_o   (b_lo0),
    .lo1_o   (b_lo1)
  );

  assign r_sum = {1'b0, r_lo0} + {1'b0, r_lo1};
  assign g_sum = {1'b0, g_lo0} + {1'b0, g_lo1};
  assign b_sum = {1'b0, b_lo0} + {1'b0, b_lo1};
  assign r_med = n_q[0] ? r_lo0 : r_sum[CW:1];
  assign g_med = n_q[0] ? g_lo0 : g_sum[CW:1];
  assign b_med = n_q[0] ? b_lo0 : b_sum[CW:1];

  // result register
  assign out_take = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_take) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_col_o      <= cx_q;
      out_row_o      <= cy_q;
      out_of_range_o <= oor_q;
      if (oor_q) begin
        med_red_o      <= '0;
        med_green_o    <= '0;
        med_blue_o     <= '0;
        window_count_o <= '0;
      end else begin
        med_red_o      <= r_med;
        med_green_o    <= g_med;
        med_blue_o     <= b_med;
        window_count_o <= rwmf_pkg::WCNT_W'(n_q);
      end
    end
  end

  assign stat_o.oor        = oor_q;
  assign stat_o.scan_last  = (i_q == rx_s) && (j_q == ry_s);
  assign stat_o.shift_done = (k_q == k_target);
  assign stat_o.out_free   = !out_valid_o || !out_stall_i;

endmodule

@@ rtl/rwmf_checker.sv @@
`include "rgb_window_median_filter_assert.svh"

module rwmf_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         cmd_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [rwmf_pkg::CHAN_W-1:0]  med_red_o,
  input logic [rwmf_pkg::CHAN_W-1:0]  med_green_o,
  input logic [rwmf_pkg::CHAN_W-1:0]  med_blue_o,
  input logic [rwmf_pkg::WCNT_W-1:0]  window_count_o,
  input logic                         out_of_range_o
);

  logic query_acc;
  logic oor_zero;

  assign query_acc = in_valid_i && !in_stall_o && (cmd_i == rwmf_pkg::CMD_QUERY);
  assign oor_zero  = (med_red_o == '0) && (med_green_o == '0) && (med_blue_o == '0) &&
                     (window_count_o == '0);

  `RWMF_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `RWMF_ASSERT_NXT(a_query_busy, clk_i, rst_ni, query_acc, in_stall_o)
  `RWMF_ASSERT_IMP(a_oor_zero, clk_i, rst_ni, out_valid_o && out_of_range_o, oor_zero)
  `RWMF_ASSERT_IMP(a_win_nonempty, clk_i, rst_ni, out_valid_o && !out_of_range_o,
                   window_count_o != '0)

endmodule

bind rgb_window_median_filter rwmf_checker u_rwmf_checker (.*);
